>>> hw/rtl/hsvc_pkg.sv
// Shared types, constants and elaboration-time tables for the HSV color classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hsvc_pkg;

	localparam int NUM_TARGETS = 4;
	localparam int PIX_W       = 8;
	localparam int MINPIX_W    = 22;
	localparam int CFG_W       = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int FIFO_DEPTH  = 4;

	// Fixed-point widths of the conversion
	localparam int STAB_W  = 20;  // round(255*4096/max), max 1044480
	localparam int HTAB_W  = 17;  // round(30*4096/diff), max 122880
	localparam int HNUM_W  = 12;  // signed hue numerator, -255..1275
	localparam int SPROD_W = PIX_W + STAB_W;
	localparam int HPROD_W = HNUM_W + HTAB_W + 1;

	// Target indexes, in priority order
	localparam logic [1:0] TGT_RED    = 2'd0;
	localparam logic [1:0] TGT_GREEN  = 2'd1;
	localparam logic [1:0] TGT_PURPLE = 2'd2;
	localparam logic [1:0] TGT_BLUE   = 2'd3;

	// Color codes reported for each target
	localparam logic [7:0] CODE_RED    = 8'h09;
	localparam logic [7:0] CODE_GREEN  = 8'h0A;
	localparam logic [7:0] CODE_PURPLE = 8'h0F;
	localparam logic [7:0] CODE_BLUE   = 8'h0C;
	localparam logic [7:0] CODE_NONE   = 8'h00;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RED_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PURPLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MINPIX   = 3'd5;

	// Reset values: h_lo, s_lo, v_lo, h_hi, s_hi, v_hi, low byte first
	localparam logic [CFG_W-1:0] RST_RED_LOW  = 48'hFFFF_0A32_6400;
	localparam logic [CFG_W-1:0] RST_RED_HIGH = 48'hFFFF_B432_64A0;
	localparam logic [CFG_W-1:0] RST_GREEN    = 48'hFFFF_5532_6424;
	localparam logic [CFG_W-1:0] RST_PURPLE   = 48'hFFFF_A032_6487;
	localparam logic [CFG_W-1:0] RST_BLUE     = 48'hFFFF_8232_6464;
	localparam logic [MINPIX_W-1:0] RST_MINPIX = 22'd500;

	typedef struct packed {
		logic [CFG_W-1:0] blue;
		logic [CFG_W-1:0] purple;
		logic [CFG_W-1:0] green;
		logic [CFG_W-1:0] red_high;
		logic [CFG_W-1:0] red_low;
	} hsvc_boxes_t;

	// One classified pixel as it travels from the front to the back part
	typedef struct packed {
		logic [NUM_TARGETS-1:0] hits;
		logic                   frame_end;
	} hsvc_hit_t;

	typedef logic [STAB_W-1:0] stab_tab_t [256];
	typedef logic [HTAB_W-1:0] htab_tab_t [256];
	typedef logic [7:0]        code_tab_t [NUM_TARGETS];

	localparam code_tab_t TARGET_CODE = '{CODE_RED, CODE_GREEN, CODE_PURPLE, CODE_BLUE};

	// Shift-subtract quotient, evaluated only while building the tables
	function automatic logic [31:0] long_div(input logic [31:0] num, input logic [31:0] den);
		logic [32:0] rem;
		logic [31:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 31; i >= 0; i--) begin
			rem = {rem[31:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Saturation scale per max value; entry 0 unused and zero
	function automatic stab_tab_t make_stab();
		stab_tab_t t;
		logic [31:0] q;
		t[0] = '0;
		for (int m = 1; m < 256; m++) begin
			q = long_div(32'd2088960 + 32'(m), 32'(2 * m));
			t[m] = q[STAB_W-1:0];
		end
		return t;
	endfunction

	// Hue scale per max-min difference; entry 0 unused and zero
	function automatic htab_tab_t make_htab();
		htab_tab_t t;
		logic [31:0] q;
		t[0] = '0;
		for (int d = 1; d < 256; d++) begin
			q = long_div(32'd245760 + 32'(d), 32'(2 * d));
			t[d] = q[HTAB_W-1:0];
		end
		return t;
	endfunction

	localparam stab_tab_t STAB = make_stab();
	localparam htab_tab_t HTAB = make_htab();

endpackage

>>> hw/rtl/hsvc_fifo.sv
// Short queue of classified pixels between the front and the back part.
// Depends on hsvc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module hsvc_fifo
	import hsvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  hsvc_hit_t push_data,
	output logic      full,
	input  logic      pop,
	output hsvc_hit_t pop_data,
	output logic      not_empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	hsvc_hit_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/hsvc_front.sv
// Front part: BGR to HSV conversion pipeline and box tests, one pixel per clock while en is high.
// Depends on hsvc_pkg for tables, widths and the hit entry type.
`timescale 1ns / 1ps

module hsvc_front
	import hsvc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [PIX_W-1:0]  in_blue,
	input  logic [PIX_W-1:0]  in_green,
	input  logic [PIX_W-1:0]  in_red,
	input  logic              in_frame_end,
	input  hsvc_boxes_t       boxes,
	output logic              out_valid,
	output hsvc_hit_t         out_data
);

	// Stage 1: max, difference and hue numerator
	logic                     v_s1;
	logic                     fe_s1;
	logic [PIX_W-1:0]         mx_s1;
	logic [PIX_W-1:0]         diff_s1;
	logic signed [HNUM_W-1:0] hnum_s1;

	// Stage 2: table lookups
	logic                     v_s2;
	logic                     fe_s2;
	logic [PIX_W-1:0]         mx_s2;
	logic [PIX_W-1:0]         diff_s2;
	logic signed [HNUM_W-1:0] hnum_s2;
	logic [STAB_W-1:0]        stab_s2;
	logic [HTAB_W-1:0]        htab_s2;

	// Stage 3: products
	logic                      v_s3;
	logic                      fe_s3;
	logic [PIX_W-1:0]          mx_s3;
	logic                      gray_s3;
	logic [SPROD_W-1:0]        sprod_s3;
	logic signed [HPROD_W-1:0] hprod_s3;

	// Stage 4: HSV values
	logic             v_s4;
	logic             fe_s4;
	logic [PIX_W-1:0] h_s4;
	logic [PIX_W-1:0] s_s4;
	logic [PIX_W-1:0] v_val_s4;

	// Stage 5: hit vector
	logic                   v_s5;
	logic                   fe_s5;
	logic [NUM_TARGETS-1:0] hits_s5;

	logic [PIX_W-1:0]         mx_c;
	logic [PIX_W-1:0]         mn_c;
	logic signed [HNUM_W-1:0] b_x;
	logic signed [HNUM_W-1:0] g_x;
	logic signed [HNUM_W-1:0] r_x;
	logic signed [HNUM_W-1:0] d_x;
	logic signed [HNUM_W-1:0] hnum_c;
	logic [SPROD_W:0]         s_round;
	logic signed [HPROD_W:0]  h_round;
	logic signed [9:0]        h_q;
	logic signed [9:0]        h_wrap;
	logic [PIX_W-1:0]         h_c;
	logic [NUM_TARGETS-1:0]   hits_c;

	function automatic logic in_box(input logic [CFG_W-1:0] box, input logic [PIX_W-1:0] h,
			input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] v);
		return (h >= box[7:0])   && (h <= box[31:24]) &&
		       (s >= box[15:8])  && (s <= box[39:32]) &&
		       (v >= box[23:16]) && (v <= box[47:40]);
	endfunction

	// Extremes and hue numerator of the incoming pixel
	always_comb begin
		mx_c = in_blue;
		if (in_green > mx_c) mx_c = in_green;
		if (in_red > mx_c)   mx_c = in_red;
		mn_c = in_blue;
		if (in_green < mn_c) mn_c = in_green;
		if (in_red < mn_c)   mn_c = in_red;
		b_x = HNUM_W'(in_blue);
		g_x = HNUM_W'(in_green);
		r_x = HNUM_W'(in_red);
		d_x = HNUM_W'(mx_c - mn_c);
		if (mx_c == in_red) begin
			hnum_c = g_x - b_x;
		end else if (mx_c == in_green) begin
			hnum_c = b_x - r_x + (d_x <<< 1);
		end else begin
			hnum_c = r_x - g_x + (d_x <<< 2);
		end
	end

	// Round the products and wrap the hue into 0..179
	always_comb begin
		s_round = {1'b0, sprod_s3} + (SPROD_W + 1)'(2048);
		h_round = {hprod_s3[HPROD_W-1], hprod_s3} + (HPROD_W + 1)'(2048);
		h_q     = 10'(h_round >>> 12);
		h_wrap  = h_q;
		if (h_wrap < 0)            h_wrap = h_wrap + 10'sd180;
		if (h_wrap >= 10'sd180)    h_wrap = h_wrap - 10'sd180;
		h_c = gray_s3 ? '0 : h_wrap[PIX_W-1:0];
	end

	// Test against the five boxes; red ORs its two boxes
	always_comb begin
		hits_c[TGT_RED]    = in_box(boxes.red_low, h_s4, s_s4, v_val_s4) ||
		                     in_box(boxes.red_high, h_s4, s_s4, v_val_s4);
		hits_c[TGT_GREEN]  = in_box(boxes.green, h_s4, s_s4, v_val_s4);
		hits_c[TGT_PURPLE] = in_box(boxes.purple, h_s4, s_s4, v_val_s4);
		hits_c[TGT_BLUE]   = in_box(boxes.blue, h_s4, s_s4, v_val_s4);
	end

	// Advance stage valids as one pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			fe_s1    <= in_frame_end;
			mx_s1    <= mx_c;
			diff_s1  <= mx_c - mn_c;
			hnum_s1  <= hnum_c;

			fe_s2    <= fe_s1;
			mx_s2    <= mx_s1;
			diff_s2  <= diff_s1;
			hnum_s2  <= hnum_s1;
			stab_s2  <= STAB[mx_s1];
			htab_s2  <= HTAB[diff_s1];

			fe_s3    <= fe_s2;
			mx_s3    <= mx_s2;
			gray_s3  <= (diff_s2 == '0);
			sprod_s3 <= SPROD_W'(diff_s2) * SPROD_W'(stab_s2);
			hprod_s3 <= HPROD_W'(hnum_s2) * $signed({{(HPROD_W-HTAB_W){1'b0}}, htab_s2});

			fe_s4    <= fe_s3;
			h_s4     <= h_c;
			s_s4     <= s_round[PIX_W+11:12];
			v_val_s4 <= mx_s3;

			fe_s5    <= fe_s4;
			hits_s5  <= hits_c;
		end
	end

	assign out_valid          = v_s5;
	assign out_data.hits      = hits_s5;
	assign out_data.frame_end = fe_s5;

endmodule

>>> hw/rtl/hsvc_back.sv
// Back part: saturating per-target counters and the end-of-frame decision.
// Depends on hsvc_pkg for target codes and the hit entry type.
`timescale 1ns / 1ps

module hsvc_back
	import hsvc_pkg::*;
#(
	parameter int COUNT_BITS = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  hsvc_hit_t           q_data,
	output logic                q_pop,
	input  logic [MINPIX_W-1:0] min_pixels,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                res_found,
	output logic [1:0]          res_index,
	output logic [7:0]          res_code
);

	localparam int CMP_W = (COUNT_BITS > MINPIX_W) ? COUNT_BITS : MINPIX_W;

	logic [COUNT_BITS-1:0] cnt_q [NUM_TARGETS];
	logic [COUNT_BITS-1:0] bumped [NUM_TARGETS];
	logic [NUM_TARGETS-1:0] over;
	logic                   res_valid_q;
	logic                   found_q;
	logic [1:0]             index_q;
	logic [7:0]             code_q;
	logic                   out_free;
	logic                   hit_any;
	logic [1:0]             hit_idx;

	assign out_free = !res_valid_q || res_ready;
	assign q_pop    = q_not_empty && (!q_data.frame_end || out_free);

	// Bump counters and compare against the threshold
	always_comb begin
		for (int k = 0; k < NUM_TARGETS; k++) begin
			if (q_data.hits[k] && (cnt_q[k] != {COUNT_BITS{1'b1}})) begin
				bumped[k] = cnt_q[k] + 1'b1;
			end else begin
				bumped[k] = cnt_q[k];
			end
			over[k] = (CMP_W'(bumped[k]) > CMP_W'(min_pixels));
		end
	end

	// Pick the first target over threshold
	always_comb begin
		hit_any = 1'b1;
		if (over[TGT_RED]) begin
			hit_idx = TGT_RED;
		end else if (over[TGT_GREEN]) begin
			hit_idx = TGT_GREEN;
		end else if (over[TGT_PURPLE]) begin
			hit_idx = TGT_PURPLE;
		end else if (over[TGT_BLUE]) begin
			hit_idx = TGT_BLUE;
		end else begin
			hit_idx = TGT_RED;
			hit_any = 1'b0;
		end
	end

	// Update counters; clear them at the end of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TARGETS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (q_pop) begin
			for (int k = 0; k < NUM_TARGETS; k++) begin
				cnt_q[k] <= q_data.frame_end ? '0 : bumped[k];
			end
		end
	end

	// Hold the result until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && q_data.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.frame_end) begin
			found_q <= hit_any;
			index_q <= hit_idx;
			code_q  <= hit_any ? TARGET_CODE[hit_idx] : CODE_NONE;
		end
	end

	assign res_valid = res_valid_q;
	assign res_found = found_q;
	assign res_index = index_q;
	assign res_code  = code_q;

endmodule

>>> hw/rtl/hsv_color_target_classifier_core.sv
// Top level of the HSV color classifier: configuration registers and the
// front pipeline, queue and back counters. Depends on hsvc_pkg and all hsvc_ modules.
`timescale 1ns / 1ps

// Takes one BGR pixel per clock on the s_ stream and emits one result on the
// m_ stream for every pixel marked with tlast. Each pixel passes a five-stage
// conversion and box-test pipeline, then a four-entry queue, then the
// counter stage, whose result register drives m_tvalid. The sustained rate is
// one pixel per cycle; the input stalls only while the queue is full, which
// happens when a finished result waits on m_tready and the next frame's last
// pixel reaches the head of the queue.
// Configuration writes take effect at the next clock and are meant for idle
// periods between frames; writes to indexes beyond the register list are ignored.
module hsv_color_target_classifier_core
	import hsvc_pkg::*;
#(
	parameter int COUNT_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Pixel stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // blue[7:0], green[15:8], red[23:16]
	input  logic                 s_tlast,   // frame_end
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // target_index[1:0], color_code[9:2], zero fill
	output logic                 m_tuser,   // found
	// Configuration
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	hsvc_boxes_t         boxes_q;
	logic [MINPIX_W-1:0] min_pixels_q;
	logic                front_en;
	logic                front_valid;
	hsvc_hit_t           front_data;
	logic                fifo_full;
	logic                fifo_not_empty;
	logic                fifo_pop;
	hsvc_hit_t           fifo_data;
	logic [1:0]          res_index;
	logic [7:0]          res_code;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boxes_q.red_low  <= RST_RED_LOW;
			boxes_q.red_high <= RST_RED_HIGH;
			boxes_q.green    <= RST_GREEN;
			boxes_q.purple   <= RST_PURPLE;
			boxes_q.blue     <= RST_BLUE;
			min_pixels_q     <= RST_MINPIX;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RED_LOW:  boxes_q.red_low  <= cfg_wdata;
				REG_RED_HIGH: boxes_q.red_high <= cfg_wdata;
				REG_GREEN:    boxes_q.green    <= cfg_wdata;
				REG_PURPLE:   boxes_q.purple   <= cfg_wdata;
				REG_BLUE:     boxes_q.blue     <= cfg_wdata;
				REG_MINPIX:   min_pixels_q     <= cfg_wdata[MINPIX_W-1:0];
				default:      ;
			endcase
		end
	end

	// Stall the front pipeline while the queue is full
	assign front_en = !fifo_full;
	assign s_tready = front_en;

	hsvc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (front_en),
		.in_valid     (s_tvalid),
		.in_blue      (s_tdata[7:0]),
		.in_green     (s_tdata[15:8]),
		.in_red       (s_tdata[23:16]),
		.in_frame_end (s_tlast),
		.boxes        (boxes_q),
		.out_valid    (front_valid),
		.out_data     (front_data)
	);

	hsvc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid && front_en),
		.push_data (front_data),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_data  (fifo_data),
		.not_empty (fifo_not_empty)
	);

	hsvc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (fifo_not_empty),
		.q_data      (fifo_data),
		.q_pop       (fifo_pop),
		.min_pixels  (min_pixels_q),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_found   (m_tuser),
		.res_index   (res_index),
		.res_code    (res_code)
	);

	assign m_tdata = {6'd0, res_code, res_index};

endmodule
